[rtl/dirty_rect_accumulator_macros.svh]
// Assertion macros for the dirty rectangle accumulator checker.
`ifndef DIRTY_RECT_ACCUMULATOR_MACROS_SVH
`define DIRTY_RECT_ACCUMULATOR_MACROS_SVH

// Checked at every clock edge, reset included.
`define DRA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

// Checked only while out of reset.
`define DRA_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

`endif

[rtl/dra_pkg.sv]
package dra_pkg;

    localparam int COORD_BITS   = 12;
    localparam int RECT_BITS    = 16;
    // wide enough for any non-negative rect edge and any coordinate
    localparam int CMP_BITS     = RECT_BITS + 1;
    localparam int CFG_IDX_BITS = 3;

    localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_WIDTH   = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_HEIGHT  = CFG_IDX_BITS'(1);
    localparam logic [CFG_IDX_BITS-1:0] CFG_OBJ_CLIP_LEFT = CFG_IDX_BITS'(2);
    localparam logic [CFG_IDX_BITS-1:0] CFG_OBJ_CLIP_TOP  = CFG_IDX_BITS'(3);
    localparam logic [CFG_IDX_BITS-1:0] CFG_OBJ_CLIP_RIGHT  = CFG_IDX_BITS'(4);
    localparam logic [CFG_IDX_BITS-1:0] CFG_OBJ_CLIP_BOTTOM = CFG_IDX_BITS'(5);
    localparam logic [CFG_IDX_BITS-1:0] CFG_OBJ_CLIP_EN   = CFG_IDX_BITS'(6);

    typedef enum logic [1:0] {
        OP_ADD        = 2'd0,
        OP_RESET      = 2'd1,
        OP_BEGIN_CLIP = 2'd2,
        OP_END_CLIP   = 2'd3
    } t_op;

    typedef logic [COORD_BITS-1:0]       t_coord;
    typedef logic signed [RECT_BITS-1:0] t_rcoord;

    typedef struct packed {
        t_coord left;
        t_coord top;
        t_coord right;
        t_coord bottom;
    } t_rect;

    typedef struct packed {
        t_coord frame_width;
        t_coord frame_height;
        t_rect  obj_clip;
        logic   obj_clip_en;
    } t_cfg;

    typedef struct packed {
        t_op     op;
        t_rcoord left;
        t_rcoord top;
        t_rcoord right;
        t_rcoord bottom;
    } t_item;

    // damage clip state seen by the clip stage
    typedef struct packed {
        t_rect edges;
        logic  active;
    } t_dclip;

    // clamped and clipped rectangle of an add
    typedef struct packed {
        t_rect rect;
        logic  empty;
    } t_clip_res;

    typedef struct packed {
        t_rect box;
        logic  nonempty;
        logic  begun;
    } t_result;

    function automatic t_coord clamp_edge(t_rcoord v, t_coord hi);
        logic [CMP_BITS-1:0] vz;
        logic [CMP_BITS-1:0] hz;
        vz = CMP_BITS'($unsigned(v));
        hz = CMP_BITS'(hi);
        if (v < 0) begin
            return '0;
        end else if (vz > hz) begin
            return hi;
        end else begin
            return COORD_BITS'(vz);
        end
    endfunction

    function automatic logic rect_zero_area(t_rect r);
        return (r.left >= r.right) || (r.top >= r.bottom);
    endfunction

    function automatic t_rect rect_isect(t_rect a, t_rect b);
        t_rect r;
        r.left   = (a.left   > b.left)   ? a.left   : b.left;
        r.top    = (a.top    > b.top)    ? a.top    : b.top;
        r.right  = (a.right  < b.right)  ? a.right  : b.right;
        r.bottom = (a.bottom < b.bottom) ? a.bottom : b.bottom;
        return r;
    endfunction

    function automatic t_rect rect_union(t_rect a, t_rect b);
        t_rect r;
        r.left   = (a.left   < b.left)   ? a.left   : b.left;
        r.top    = (a.top    < b.top)    ? a.top    : b.top;
        r.right  = (a.right  > b.right)  ? a.right  : b.right;
        r.bottom = (a.bottom > b.bottom) ? a.bottom : b.bottom;
        return r;
    endfunction

endpackage

[rtl/dra_if.sv]
interface dra_in_if import dra_pkg::*; ();
    logic    valid;
    logic    ready;
    t_op     operation;
    t_rcoord rect_left;
    t_rcoord rect_top;
    t_rcoord rect_right;
    t_rcoord rect_bottom;

    modport source (output valid, operation, rect_left, rect_top, rect_right, rect_bottom,
                    input ready);
    modport sink   (input valid, operation, rect_left, rect_top, rect_right, rect_bottom,
                    output ready);
endinterface

interface dra_out_if import dra_pkg::*; ();
    logic   valid;
    logic   ready;
    t_coord damage_left;
    t_coord damage_top;
    t_coord damage_right;
    t_coord damage_bottom;
    logic   damage_nonempty;
    logic   clip_begun;

    modport source (output valid, damage_left, damage_top, damage_right, damage_bottom,
                    damage_nonempty, clip_begun, input ready);
    modport sink   (input valid, damage_left, damage_top, damage_right, damage_bottom,
                    damage_nonempty, clip_begun, output ready);
endinterface

interface dra_cfg_if import dra_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [CFG_IDX_BITS-1:0] index;
    t_coord                  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[rtl/dra_cfg_regs.sv]
module dra_cfg_regs import dra_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    dra_cfg_if.sink  i_cfg,
    output t_cfg     o_cfg
);

    t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_FRAME_WIDTH:     r_cfg.frame_width     <= i_cfg.data;
                CFG_FRAME_HEIGHT:    r_cfg.frame_height    <= i_cfg.data;
                CFG_OBJ_CLIP_LEFT:   r_cfg.obj_clip.left   <= i_cfg.data;
                CFG_OBJ_CLIP_TOP:    r_cfg.obj_clip.top    <= i_cfg.data;
                CFG_OBJ_CLIP_RIGHT:  r_cfg.obj_clip.right  <= i_cfg.data;
                CFG_OBJ_CLIP_BOTTOM: r_cfg.obj_clip.bottom <= i_cfg.data;
                CFG_OBJ_CLIP_EN:     r_cfg.obj_clip_en     <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

endmodule

[rtl/dra_clip.sv]
module dra_clip import dra_pkg::*; (
    input  t_item     i_item,
    input  t_cfg      i_cfg,
    input  t_dclip    i_dclip,
    output t_clip_res o_clip
);

    t_rect w_clamped;
    t_rect w_dclipped;
    t_rect w_oclipped;

    always_comb begin
        w_clamped.left   = clamp_edge(i_item.left,   i_cfg.frame_width);
        w_clamped.top    = clamp_edge(i_item.top,    i_cfg.frame_height);
        w_clamped.right  = clamp_edge(i_item.right,  i_cfg.frame_width);
        w_clamped.bottom = clamp_edge(i_item.bottom, i_cfg.frame_height);

        w_dclipped = i_dclip.active ? rect_isect(w_clamped, i_dclip.edges) : w_clamped;
        w_oclipped = i_cfg.obj_clip_en ? rect_isect(w_dclipped, i_cfg.obj_clip) : w_dclipped;

        o_clip.rect  = w_oclipped;
        o_clip.empty = rect_zero_area(w_oclipped);
    end

endmodule

[rtl/dra_box.sv]
module dra_box import dra_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_step,
    input  t_op       i_op,
    input  t_clip_res i_clip,
    output t_dclip    o_dclip,
    output t_result   o_result
);

    t_rect   r_box;
    t_dclip  r_dclip;
    t_result r_result;

    t_rect   n_box;
    t_dclip  n_dclip;
    logic    n_begun;

    always_comb begin
        n_box   = r_box;
        n_dclip = r_dclip;
        n_begun = 1'b0;
        case (i_op)
            OP_ADD: begin
                if (!i_clip.empty) begin
                    n_box = rect_zero_area(r_box) ? i_clip.rect : rect_union(r_box, i_clip.rect);
                end
            end
            OP_RESET: begin
                n_box = '0;
            end
            OP_BEGIN_CLIP: begin
                if (!rect_zero_area(r_box)) begin
                    n_dclip.edges  = r_box;
                    n_dclip.active = 1'b1;
                    n_begun        = 1'b1;
                end
            end
            OP_END_CLIP: begin
                n_dclip.active = 1'b0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box   <= '0;
            r_dclip <= '0;
        end else if (i_step) begin
            r_box   <= n_box;
            r_dclip <= n_dclip;
        end
    end

    // result payload, no reset
    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_result <= '{box: n_box, nonempty: !rect_zero_area(n_box), begun: n_begun};
        end
    end

    assign o_dclip  = r_dclip;
    assign o_result = r_result;

endmodule

[rtl/dirty_rect_accumulator.sv]
// Dirty rectangle accumulator: keeps one bounding box over all damage drawn in a frame.
// Each input transfer carries an operation: add (clamp the signed rectangle to the frame,
// intersect with the damage clip when active and the object clip when enabled, then
// merge into the box unless empty), reset (clear the box), begin clip (copy a non-empty
// box into the damage clip, clip_begun = 1) or end clip (drop the damage clip). Every
// input transfer yields exactly one output transfer with the box after that step.
// Throughput is one transfer per cycle while the output is ready; each input transfer
// passes the input register, then the clip/merge logic into the box and result register,
// before output valid rises. The per-item path is the clamp, two intersections and the
// min/max merge feeding back into the box register. Configuration is to be written only
// while the block is idle; the user is bound to this and the block itself does not enforce
// it. The config channel is always ready. No clearing pass after reset.
module dirty_rect_accumulator import dra_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    dra_in_if.sink    i_in,
    dra_cfg_if.sink   i_cfg,
    dra_out_if.source o_res
);

    // input register
    logic    r_in_valid;
    t_item   r_item;
    // output register control; payload sits in dra_box
    logic    r_out_valid;

    logic      w_step;
    t_cfg      w_cfg;
    t_dclip    w_dclip;
    t_clip_res w_clip;
    t_result   w_result;

    // item moves into the result register when the output slot is free or being drained
    assign w_step     = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_in.ready = !r_in_valid || w_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (w_step) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_item <= '{op:     i_in.operation,
                        left:   i_in.rect_left,
                        top:    i_in.rect_top,
                        right:  i_in.rect_right,
                        bottom: i_in.rect_bottom};
        end
    end

    dra_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    dra_clip u_clip (
        .i_item  (r_item),
        .i_cfg   (w_cfg),
        .i_dclip (w_dclip),
        .o_clip  (w_clip)
    );

    dra_box u_box (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_op     (r_item.op),
        .i_clip   (w_clip),
        .o_dclip  (w_dclip),
        .o_result (w_result)
    );

    assign o_res.valid           = r_out_valid;
    assign o_res.damage_left     = w_result.box.left;
    assign o_res.damage_top      = w_result.box.top;
    assign o_res.damage_right    = w_result.box.right;
    assign o_res.damage_bottom   = w_result.box.bottom;
    assign o_res.damage_nonempty = w_result.nonempty;
    assign o_res.clip_begun      = w_result.begun;

endmodule

[rtl/dra_checker.sv]
`include "dirty_rect_accumulator_macros.svh"

module dra_checker import dra_pkg::*; (
    input logic   i_clk,
    input logic   i_rst_n,
    input logic   i_res_valid,
    input logic   i_res_ready,
    input t_coord i_res_left,
    input t_coord i_res_top,
    input t_coord i_res_right,
    input t_coord i_res_bottom,
    input logic   i_res_nonempty,
    input logic   i_res_begun
);

    `DRA_ASSERT(a_reset_clears_out, !i_rst_n |=> !i_res_valid, "output valid after reset")

    `DRA_ASSERT_RST(a_out_hold, (i_res_valid && !i_res_ready) |=> (i_res_valid && $stable(i_res_left) && $stable(i_res_top) && $stable(i_res_right) && $stable(i_res_bottom) && $stable(i_res_nonempty) && $stable(i_res_begun)), "stalled result changed")

    `DRA_ASSERT_RST(a_nonempty_flag, i_res_valid |-> (i_res_nonempty == ((i_res_right > i_res_left) && (i_res_bottom > i_res_top))), "nonempty flag disagrees with box")

    `DRA_ASSERT_RST(a_begun_needs_box, (i_res_valid && i_res_begun) |-> i_res_nonempty, "clip begun on empty box")

endmodule

bind dirty_rect_accumulator dra_checker u_dra_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_res_valid    (o_res.valid),
    .i_res_ready    (o_res.ready),
    .i_res_left     (o_res.damage_left),
    .i_res_top      (o_res.damage_top),
    .i_res_right    (o_res.damage_right),
    .i_res_bottom   (o_res.damage_bottom),
    .i_res_nonempty (o_res.damage_nonempty),
    .i_res_begun    (o_res.clip_begun)
);
